### rtl/trs_pkg.sv
`default_nettype none
package trs_pkg;

    // One input beat
    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] field_name;
        logic [31:0] value;
        logic [1:0]  width_code;
        logic        is_signed;
        logic [15:0] item_count;
        logic        final_element;
    } trs_in_t;

    // One output beat
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_end;
    } trs_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic check;
        logic mul;
        logic sub;
        logic emit;
    } trs_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic go;
        logic num_en;
        logic conv_done;
        logic emit_ok;
        logic emit_last;
    } trs_sts_t;

    localparam logic [3:0] K_OPEN      = 4'd0;
    localparam logic [3:0] K_SUBOPEN   = 4'd1;
    localparam logic [3:0] K_CLOSE     = 4'd2;
    localparam logic [3:0] K_CHAR      = 4'd3;
    localparam logic [3:0] K_BOOL      = 4'd4;
    localparam logic [3:0] K_SINT      = 4'd5;
    localparam logic [3:0] K_UINT      = 4'd6;
    localparam logic [3:0] K_STRHDR    = 4'd7;
    localparam logic [3:0] K_STRCHAR   = 4'd8;
    localparam logic [3:0] K_ARRHDR    = 4'd9;
    localparam logic [3:0] K_ARRELEM   = 4'd10;
    localparam logic [3:0] K_FLUSH     = 4'd11;
    localparam logic [3:0] K_FLUSHPART = 4'd12;

    localparam logic [1:0] WC_BYTE = 2'd0;
    localparam logic [1:0] WC_HALF = 2'd1;

    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_TWO    = 8'h32;
    localparam logic [7:0] CH_FOUR   = 8'h34;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_QUOTE  = 8'h27;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PCT    = 8'h25;

    localparam logic [31:0] RECIP10   = 32'hCCCCCCCD;
    localparam logic [4:0]  MAX_BEATS = 5'd16;
    localparam logic [3:0]  MAX_DIGS  = 4'd10;

endpackage
`default_nettype wire

### rtl/trs_ctrl.sv
`default_nettype none
module trs_ctrl
    import trs_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire trs_sts_t sts,
    output trs_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_SUB   = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Sequencing and command decode
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check = 1'b1;
                if (!sts.go)
                    state_next = S_IDLE;
                else if (sts.num_en)
                    state_next = S_MUL;
                else
                    state_next = S_EMIT;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUB;
            end
            S_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = sts.conv_done ? S_EMIT : S_MUL;
            end
            S_EMIT:
            begin
                if (sts.emit_ok)
                begin
                    cmd.emit = 1'b1;
                    if (sts.emit_last)
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

### rtl/trs_datapath.sv
`default_nettype none
module trs_datapath
    import trs_pkg::*;
#(
    parameter int BUFFER_LEN = 256
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire trs_in_t  in_item,
    input  wire trs_cmd_t cmd,
    output trs_sts_t      sts,
    output logic          out_valid,
    input  wire logic     out_ready,
    output trs_out_t      out_item
);

    localparam int FW = $clog2(BUFFER_LEN + 1);
    localparam logic [FW-1:0] FILL_MAX = FW'(BUFFER_LEN);
    localparam logic [20:0]   BUF_LIM  = 21'(BUFFER_LEN);

    // Architectural state
    logic [FW-1:0] fill_reg, fill_next;
    logic [15:0]   sum_reg, sum_next;
    logic [7:0]    depth_reg, depth_next;
    logic          la_reg, la_next;
    logic          first_reg, first_next;
    logic [2:0]    amode_reg, amode_next;

    // Item and plan
    trs_in_t     item_reg;
    logic [7:0]  pre_reg [6];
    logic [2:0]  pre_n_reg;
    logic        post_reg;
    logic        nl_reg;
    logic [31:0] num_reg;
    logic [63:0] prod_reg;
    logic [3:0]  dig_reg [10];
    logic [3:0]  dig_n_reg;
    logic [4:0]  e_reg;
    logic        out_valid_reg;
    trs_out_t    out_reg;

    // Plan decode
    logic [7:0]  pre_c [6];
    logic [2:0]  pre_n_c;
    logic        post_c, nl_c, num_en_c, go_c, fits_c;
    logic [31:0] num_c;
    logic [20:0] need_c;
    logic [1:0]  wc_c;
    logic        sg_c;
    logic [31:0] sval_c, uval_c, mag_c;
    logic        neg_c;
    logic [7:0]  szch_c;
    logic [3:0]  per_c;
    logic [15:0] sum_brace_c;

    always_comb
    begin
        for (int i = 0; i < 6; i++)
            pre_c[i] = CH_NL;
        pre_n_c  = '0;
        post_c   = 1'b0;
        nl_c     = 1'b0;
        num_en_c = 1'b0;
        num_c    = '0;
        need_c   = '0;
        go_c     = 1'b0;
        fits_c   = 1'b0;

        // element format follows the array mode for array elements
        wc_c = (item_reg.kind == K_ARRELEM) ? amode_reg[1:0] : item_reg.width_code;
        sg_c = (item_reg.kind == K_ARRELEM) ? amode_reg[2] : (item_reg.kind == K_SINT);
        case (wc_c)
            WC_BYTE: begin
                uval_c = {24'd0, item_reg.value[7:0]};
                sval_c = {{24{item_reg.value[7]}}, item_reg.value[7:0]};
                szch_c = CH_ONE;
            end
            WC_HALF: begin
                uval_c = {16'd0, item_reg.value[15:0]};
                sval_c = {{16{item_reg.value[15]}}, item_reg.value[15:0]};
                szch_c = CH_TWO;
            end
            default: begin
                uval_c = item_reg.value;
                sval_c = item_reg.value;
                szch_c = CH_FOUR;
            end
        endcase
        neg_c = sg_c && sval_c[31];
        mag_c = sg_c ? (neg_c ? (32'd0 - sval_c) : sval_c) : uval_c;
        case (item_reg.width_code)
            WC_BYTE: per_c = item_reg.is_signed ? 4'd5 : 4'd4;
            WC_HALF: per_c = item_reg.is_signed ? 4'd7 : 4'd6;
            default: per_c = item_reg.is_signed ? 4'd12 : 4'd11;
        endcase
        sum_brace_c = {sum_reg[14:0], sum_reg[15]} ^ {8'd0, CH_RBRACE};

        case (item_reg.kind)
            K_OPEN, K_SUBOPEN: begin
                need_c   = 21'd3;
                pre_c[0] = (item_reg.kind == K_OPEN) ? CH_LBRACE : CH_LBRACK;
                pre_c[1] = item_reg.field_name[15:8];
                pre_c[2] = item_reg.field_name[7:0];
                pre_n_c  = 3'd3;
                nl_c     = 1'b1;
            end
            K_CLOSE: begin
                nl_c    = 1'b1;
                pre_n_c = 3'd1;
                if (depth_reg != 8'd0)
                begin
                    need_c   = 21'd1;
                    pre_c[0] = CH_RBRACK;
                end
                else
                begin
                    need_c   = 21'd6;
                    pre_c[0] = CH_RBRACE;
                    num_en_c = 1'b1;
                    num_c    = {16'd0, sum_brace_c};
                end
            end
            K_CHAR, K_BOOL: begin
                need_c   = 21'd5;
                pre_c[0] = item_reg.field_name[15:8];
                pre_c[1] = item_reg.field_name[7:0];
                pre_c[2] = (item_reg.kind == K_CHAR) ? CH_QUOTE : CH_QMARK;
                pre_c[3] = CH_COLON;
                if (item_reg.kind == K_CHAR)
                    pre_c[4] = item_reg.value[7:0];
                else
                    pre_c[4] = (item_reg.value[7:0] != 8'd0) ? CH_ONE : CH_ZERO;
                pre_n_c  = 3'd5;
                nl_c     = 1'b1;
            end
            K_SINT, K_UINT: begin
                case (item_reg.width_code)
                    WC_BYTE: need_c = 21'd8;
                    WC_HALF: need_c = 21'd10;
                    default: need_c = 21'd15;
                endcase
                if (item_reg.kind == K_SINT)
                    need_c = need_c + 21'd1;
                pre_c[0] = item_reg.field_name[15:8];
                pre_c[1] = item_reg.field_name[7:0];
                pre_c[2] = (item_reg.kind == K_SINT) ? CH_MINUS : CH_PLUS;
                pre_c[3] = szch_c;
                pre_c[4] = CH_COLON;
                pre_c[5] = CH_MINUS;
                pre_n_c  = neg_c ? 3'd6 : 3'd5;
                num_en_c = 1'b1;
                num_c    = mag_c;
                nl_c     = 1'b1;
            end
            K_STRHDR: begin
                need_c   = 21'd9 + {5'd0, item_reg.item_count};
                pre_c[0] = item_reg.field_name[15:8];
                pre_c[1] = item_reg.field_name[7:0];
                pre_c[2] = CH_DQUOTE;
                pre_n_c  = 3'd3;
                num_en_c = 1'b1;
                num_c    = {16'd0, item_reg.item_count};
                post_c   = 1'b1;
                nl_c     = (item_reg.item_count == 16'd0);
            end
            K_ARRHDR: begin
                // full 20-bit product: count times bytes per element
                need_c   = 21'd11 + {1'b0, 20'(item_reg.item_count) * 20'(per_c)};
                pre_c[0] = item_reg.field_name[15:8];
                pre_c[1] = item_reg.field_name[7:0];
                pre_c[2] = item_reg.is_signed ? CH_HASH : CH_PCT;
                pre_c[3] = szch_c;
                pre_c[4] = CH_COLON;
                pre_n_c  = 3'd5;
                num_en_c = 1'b1;
                num_c    = {16'd0, item_reg.item_count};
                post_c   = 1'b1;
                nl_c     = (item_reg.item_count == 16'd0);
            end
            K_STRCHAR: begin
                pre_c[0] = item_reg.value[7:0];
                pre_n_c  = 3'd1;
                nl_c     = item_reg.final_element;
            end
            K_ARRELEM: begin
                if (!first_reg)
                begin
                    pre_c[0] = CH_COMMA;
                    pre_c[1] = CH_MINUS;
                    pre_n_c  = neg_c ? 3'd2 : 3'd1;
                end
                else
                begin
                    pre_c[0] = CH_MINUS;
                    pre_n_c  = neg_c ? 3'd1 : 3'd0;
                end
                num_en_c = 1'b1;
                num_c    = mag_c;
                nl_c     = item_reg.final_element;
            end
            default: begin
                need_c = '0;
            end
        endcase

        fits_c = ({{(21-FW){1'b0}}, fill_reg} + need_c + 21'd2) <= BUF_LIM;
        case (item_reg.kind)
            K_OPEN, K_SUBOPEN, K_CLOSE, K_CHAR, K_BOOL, K_SINT, K_UINT,
            K_STRHDR, K_ARRHDR:  go_c = fits_c;
            K_STRCHAR, K_ARRELEM: go_c = la_reg;
            default:             go_c = 1'b0;
        endcase
    end

    // Digit step: quotient from reciprocal product, remainder by shift-add
    logic [28:0] quot_c;
    logic [31:0] rem_c;
    assign quot_c = prod_reg[63:35];
    assign rem_c  = num_reg - ({quot_c, 3'b000} + {2'b00, quot_c, 1'b0});

    // Emit byte selection
    logic [4:0] tot_c, dstart_c, dend_c, doff_c;
    logic [3:0] didx_c;
    logic [7:0] byte_c;
    logic       nl_slot_c;
    assign dstart_c = {2'b00, pre_n_reg};
    assign dend_c   = dstart_c + {1'b0, dig_n_reg};
    assign tot_c    = dend_c + {4'd0, post_reg} + {4'd0, nl_reg};
    assign doff_c   = e_reg - dstart_c;
    assign didx_c   = dig_n_reg - 4'd1 - doff_c[3:0];

    always_comb
    begin
        nl_slot_c = 1'b0;
        if (e_reg < dstart_c)
            byte_c = pre_reg[e_reg[2:0]];
        else if (e_reg < dend_c)
            byte_c = CH_ZERO + {4'd0, dig_reg[didx_c]};
        else if (post_reg && (e_reg == dend_c))
            byte_c = CH_COLON;
        else
        begin
            byte_c    = CH_NL;
            nl_slot_c = 1'b1;
        end
    end

    always_comb
    begin
        sts.go        = go_c;
        sts.num_en    = num_en_c;
        sts.conv_done = (quot_c == 29'd0) || (dig_n_reg == (MAX_DIGS - 4'd1));
        sts.emit_ok   = !out_valid_reg || out_ready || (e_reg >= MAX_BEATS);
        sts.emit_last = (e_reg == (tot_c - 5'd1));
    end

    // Architectural state update
    always_comb
    begin
        fill_next  = fill_reg;
        sum_next   = sum_reg;
        depth_next = depth_reg;
        la_next    = la_reg;
        first_next = first_reg;
        amode_next = amode_reg;
        if (cmd.load)
        begin
            case (in_item.kind)
                K_OPEN: begin
                    fill_next  = '0;
                    sum_next   = '0;
                    depth_next = '0;
                    la_next    = 1'b0;
                    first_next = 1'b1;
                end
                K_FLUSH: begin
                    fill_next  = '0;
                    sum_next   = '0;
                    depth_next = '0;
                end
                K_FLUSHPART: fill_next = '0;
                default: fill_next = fill_reg;
            endcase
        end
        if (cmd.check && go_c)
        begin
            case (item_reg.kind)
                K_SUBOPEN: depth_next = depth_reg + 8'd1;
                K_CLOSE: begin
                    if (depth_reg != 8'd0)
                        depth_next = depth_reg - 8'd1;
                end
                K_STRHDR: begin
                    if (item_reg.item_count != 16'd0)
                        la_next = 1'b1;
                end
                K_ARRHDR: begin
                    if (item_reg.item_count != 16'd0)
                    begin
                        la_next    = 1'b1;
                        first_next = 1'b1;
                        amode_next = {item_reg.is_signed, item_reg.width_code};
                    end
                end
                K_STRCHAR: begin
                    if (item_reg.final_element)
                        la_next = 1'b0;
                end
                K_ARRELEM: begin
                    first_next = 1'b0;
                    if (item_reg.final_element)
                    begin
                        la_next    = 1'b0;
                        first_next = 1'b1;
                    end
                end
                default: depth_next = depth_reg;
            endcase
        end
        if (cmd.emit)
        begin
            if (!nl_slot_c)
                sum_next = {sum_reg[14:0], sum_reg[15]} ^ {8'd0, byte_c};
            if (fill_reg != FILL_MAX)
                fill_next = fill_reg + {{(FW-1){1'b0}}, 1'b1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            sum_reg       <= '0;
            depth_reg     <= '0;
            la_reg        <= 1'b0;
            first_reg     <= 1'b1;
            amode_reg     <= '0;
            out_valid_reg <= 1'b0;
            e_reg         <= '0;
            dig_n_reg     <= '0;
        end
        else
        begin
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            depth_reg <= depth_next;
            la_reg    <= la_next;
            first_reg <= first_next;
            amode_reg <= amode_next;
            if (cmd.check)
            begin
                e_reg     <= '0;
                dig_n_reg <= '0;
            end
            else if (cmd.sub)
                dig_n_reg <= dig_n_reg + 4'd1;
            else if (cmd.emit)
                e_reg <= e_reg + 5'd1;
            // new beat loads the output register, else a taken beat empties it
            if (cmd.emit && (e_reg < MAX_BEATS))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.check)
        begin
            for (int i = 0; i < 6; i++)
                pre_reg[i] <= pre_c[i];
            pre_n_reg  <= pre_n_c;
            post_reg   <= post_c;
            nl_reg     <= nl_c;
            num_reg    <= num_c;
        end
        if (cmd.mul)
            prod_reg <= num_reg * RECIP10;
        if (cmd.sub)
        begin
            dig_reg[dig_n_reg] <= rem_c[3:0];
            num_reg            <= {3'd0, quot_c};
        end
        if (cmd.emit && (e_reg < MAX_BEATS))
        begin
            out_reg.out_byte <= byte_c;
            out_reg.run_end  <= sts.emit_last || (e_reg == (MAX_BEATS - 5'd1));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

endmodule
`default_nettype wire

### rtl/text_record_serializer_unit.sv
// Flow: an input beat is registered and checked, then a number is converted
//   one decimal digit at a time (10 at most), by a multiply and a subtract step.
// Throughput: a new item is taken only after the last byte of the previous one;
//   the output side sends one byte per cycle unless a stalled beat waits on out_ready.
// Reset: rst_n asynchronous active low; counters, checksum and depth clear.
`default_nettype none
module text_record_serializer_unit
    import trs_pkg::*;
#(
    parameter int BUFFER_LEN = 256
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire trs_in_t in_item,
    output logic         out_valid,
    input  wire logic    out_ready,
    output trs_out_t     out_item
);

    trs_cmd_t cmd;
    trs_sts_t sts;

    trs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    trs_datapath #(
        .BUFFER_LEN (BUFFER_LEN)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule
`default_nettype wire

### rtl/trs_checker.sv
`default_nettype none
module trs_checker
    import trs_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     in_valid,
    input wire logic     in_ready,
    input wire trs_in_t  in_item,
    input wire logic     out_valid,
    input wire logic     out_ready,
    input wire trs_out_t out_item
);

    // stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output beat changed while stalled");

    // an accepted item keeps the input closed for the next cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input reopened right after accept");

    // a pending non-final byte means the item is still in work
    a_no_accept_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.run_end |-> !in_ready)
        else $error("input open while item bytes remain");

    // a waiting input beat holds until taken
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_item))
        else $error("input beat changed while waiting");

endmodule

bind text_record_serializer_unit trs_checker u_trs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);
`default_nettype wire
